/* hw/rtl/fsft_pkg.sv */
`default_nettype none

package fsft_pkg;

    // Defaults and fixed constants of the timer.
    localparam int unsigned DEF_TICKS_PER_SECOND = 10000000;
    localparam int unsigned SNAP_DIVISOR         = 4000;

    localparam logic [31:0] RST_COUNTER_FREQUENCY = 32'd10000000;
    localparam logic [31:0] RST_MAX_DELTA_COUNTS  = 32'd1000000;
    localparam logic        RST_FIXED_STEP        = 1'b0;
    localparam logic [31:0] RST_TARGET_STEP_TICKS = 32'd166666;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNTER_FREQUENCY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DELTA_COUNTS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIXED_STEP        = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_STEP_TICKS = 2'd3;

    // Item opcodes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    // Shared divider: 64-bit dividend, 32-bit divisor, two quotient bits a cycle.
    localparam int unsigned DIV_DIVIDEND_W = 64;
    localparam int unsigned DIV_DIVISOR_W  = 32;
    localparam int unsigned DIV_BITS_PER_CYCLE = 2;
    localparam int unsigned DIV_CYCLES = DIV_DIVIDEND_W / DIV_BITS_PER_CYCLE;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic        op;
        logic [63:0] timestamp;
    } in_item_t;

    typedef struct packed {
        logic        rendered;
        logic [63:0] elapsed_ticks;
        logic [63:0] total_ticks;
        logic [31:0] frame_count;
        logic [31:0] frames_per_second;
    } out_item_t;

    // Datapath operations of one microcode step.
    typedef enum logic [3:0] {
        U_NOP,
        U_ACCEPT,
        U_DELTA,
        U_ACCUM,
        U_MUL,
        U_CONV_START,
        U_CONV_DONE,
        U_SNAP,
        U_LEFT_ADD,
        U_FIRE_FIXED,
        U_MOD_START,
        U_MOD_DONE,
        U_FIRE_VAR,
        U_SEC_START,
        U_SEC_DONE,
        U_FINISH
    } uop_t;

    // Branch conditions; the reset op has no uop of its own but a U_NOP step with clear_elapsed set.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_REQ_RESET,
        C_NOT_FIXED,
        C_NO_FIRE,
        C_TARGET_ZERO,
        C_SEC_LOW,
        C_DIV_BUSY,
        C_OUT_FULL
    } cond_t;

    typedef logic [4:0] step_t;

    localparam step_t STEP_ACCEPT     = 5'd0;
    localparam step_t STEP_DELTA      = 5'd1;
    localparam step_t STEP_ACCUM      = 5'd2;
    localparam step_t STEP_MUL        = 5'd3;
    localparam step_t STEP_CONV_START = 5'd4;
    localparam step_t STEP_CONV_WAIT  = 5'd5;
    localparam step_t STEP_CONV_DONE  = 5'd6;
    localparam step_t STEP_SNAP       = 5'd7;
    localparam step_t STEP_LEFT_ADD   = 5'd8;
    localparam step_t STEP_FIRE_TEST  = 5'd9;
    localparam step_t STEP_FIRE_FIXED = 5'd10;
    localparam step_t STEP_MOD_START  = 5'd11;
    localparam step_t STEP_MOD_WAIT   = 5'd12;
    localparam step_t STEP_MOD_DONE   = 5'd13;
    localparam step_t STEP_FIRE_VAR   = 5'd14;
    localparam step_t STEP_SEC_TEST   = 5'd15;
    localparam step_t STEP_SEC_START  = 5'd16;
    localparam step_t STEP_SEC_WAIT   = 5'd17;
    localparam step_t STEP_SEC_DONE   = 5'd18;
    localparam step_t STEP_FINISH     = 5'd19;
    localparam step_t STEP_RESET      = 5'd20;

    // One control word: the operation, a clear flag for the reset op, a hold condition that keeps the step,
    // and a jump condition with its target. Otherwise the next step follows.
    typedef struct packed {
        uop_t  uop;
        logic  clear_elapsed;
        cond_t hold;
        cond_t jump;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '{uop: U_NOP, clear_elapsed: 1'b0, hold: C_NEVER, jump: C_ALWAYS,
              target: STEP_ACCEPT};
        unique case (s)
            STEP_ACCEPT:     w = '{U_ACCEPT, 1'b0, C_NO_INPUT, C_REQ_RESET, STEP_RESET};
            STEP_DELTA:      w = '{U_DELTA, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_ACCUM:      w = '{U_ACCUM, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_MUL:        w = '{U_MUL, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_CONV_START: w = '{U_CONV_START, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_CONV_WAIT:  w = '{U_NOP, 1'b0, C_DIV_BUSY, C_NEVER, STEP_ACCEPT};
            STEP_CONV_DONE:  w = '{U_CONV_DONE, 1'b0, C_NEVER, C_NOT_FIXED, STEP_FIRE_VAR};
            STEP_SNAP:       w = '{U_SNAP, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_LEFT_ADD:   w = '{U_LEFT_ADD, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_FIRE_TEST:  w = '{U_NOP, 1'b0, C_NEVER, C_NO_FIRE, STEP_SEC_TEST};
            STEP_FIRE_FIXED: w = '{U_FIRE_FIXED, 1'b0, C_NEVER, C_TARGET_ZERO, STEP_SEC_TEST};
            STEP_MOD_START:  w = '{U_MOD_START, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_MOD_WAIT:   w = '{U_NOP, 1'b0, C_DIV_BUSY, C_NEVER, STEP_ACCEPT};
            STEP_MOD_DONE:   w = '{U_MOD_DONE, 1'b0, C_NEVER, C_ALWAYS, STEP_SEC_TEST};
            STEP_FIRE_VAR:   w = '{U_FIRE_VAR, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_SEC_TEST:   w = '{U_NOP, 1'b0, C_NEVER, C_SEC_LOW, STEP_FINISH};
            STEP_SEC_START:  w = '{U_SEC_START, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_SEC_WAIT:   w = '{U_NOP, 1'b0, C_DIV_BUSY, C_NEVER, STEP_ACCEPT};
            STEP_SEC_DONE:   w = '{U_SEC_DONE, 1'b0, C_NEVER, C_NEVER, STEP_ACCEPT};
            STEP_FINISH:     w = '{U_FINISH, 1'b0, C_OUT_FULL, C_ALWAYS, STEP_ACCEPT};
            STEP_RESET:      w = '{U_NOP, 1'b1, C_NEVER, C_ALWAYS, STEP_FINISH};
            default:         w = '{U_NOP, 1'b0, C_NEVER, C_ALWAYS, STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/fsft_stream_if.sv */
`default_nettype none

// Valid/ready channel carrying one item of type item_t.
interface fsft_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fsft_div.sv */
`default_nettype none

// Restoring divider, two quotient bits a cycle. The divisor must be nonzero.
module fsft_div
    import fsft_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DIV_DIVIDEND_W-1:0] dividend,
    input  wire logic [DIV_DIVISOR_W-1:0]  divisor,
    output logic                           busy,
    output logic [DIV_DIVIDEND_W-1:0]      quotient,
    output logic [DIV_DIVISOR_W-1:0]       remainder
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

    logic                      busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIV_DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIV_DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIV_DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIV_DIVISOR_W:0]    step_hi, step_lo;

    // One compare-and-subtract: returns {quotient bit, new remainder}.
    function automatic logic [DIV_DIVISOR_W:0] div_step(
        input logic [DIV_DIVISOR_W-1:0] rem,
        input logic                     bit_in,
        input logic [DIV_DIVISOR_W-1:0] dsr
    );
        logic [DIV_DIVISOR_W:0] shifted;
        logic [DIV_DIVISOR_W:0] diff;
        shifted = {rem, bit_in};
        diff    = shifted - {1'b0, dsr};
        if (shifted >= {1'b0, dsr})
        begin
            return {1'b1, diff[DIV_DIVISOR_W-1:0]};
        end
        return {1'b0, shifted[DIV_DIVISOR_W-1:0]};
    endfunction

    // The dividend shifts out of the top of quo_reg as quotient bits enter below.
    assign step_hi = div_step(rem_reg, quo_reg[DIV_DIVIDEND_W-1], dsr_reg);
    assign step_lo = div_step(step_hi[DIV_DIVISOR_W-1:0], quo_reg[DIV_DIVIDEND_W-2],
                              dsr_reg);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = step_lo[DIV_DIVISOR_W-1:0];
            quo_next = {quo_reg[DIV_DIVIDEND_W-3:0], step_hi[DIV_DIVISOR_W],
                        step_lo[DIV_DIVISOR_W]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* hw/rtl/fixed_step_frame_timer.sv */
`default_nettype none

// Frame timer for a game loop. Each item on req carries an op (tick or reset
// elapsed time) and a 64-bit timestamp; each item yields exactly one result on
// rsp with the frame flag, the ticks of the last frame, the total ticks, the
// frame count and the frames per second latched at the last full counter
// second. One item is worked on at a time by a small microcoded sequencer; the
// next item is taken as soon as the sequencer is back at its accept step, even
// while the previous result still sits in the output register. A reset op
// goes from the accept step through the reset step to the finish step. A
// tick converts the delta with the divider; a fixed-mode frame adds the
// leftover modulo (skipped when the step is zero), and crossing a counter
// second adds the one-second modulo. The finish step holds while a full
// output register waits on the receiver. All three divisions use the single
// shared divider, which retires two quotient bits a cycle over a 64-bit
// dividend. Configuration writes take effect at once and are meant to be made
// only while the block is idle.
module fixed_step_frame_timer
    import fsft_pkg::*;
#(
    parameter int unsigned TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    fsft_stream_if.sink                 req,
    fsft_stream_if.source               rsp,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [31:0] TPS_W       = 32'(TICKS_PER_SECOND);
    localparam logic [63:0] SNAP_WINDOW = 64'(TICKS_PER_SECOND / SNAP_DIVISOR);

    // Configuration registers.
    logic [31:0] counter_frequency_reg, counter_frequency_next;
    logic [31:0] max_delta_counts_reg, max_delta_counts_next;
    logic        fixed_step_reg, fixed_step_next;
    logic [31:0] target_step_ticks_reg, target_step_ticks_next;

    // Sequencer and item registers.
    step_t       step_reg, step_next;
    logic [63:0] ts_reg, ts_next;
    logic [63:0] work_reg, work_next;
    logic        fired_reg, fired_next;

    // Timer state.
    logic [63:0] last_ts_reg, last_ts_next;
    logic [63:0] sec_acc_reg, sec_acc_next;
    logic [63:0] leftover_reg, leftover_next;
    logic [63:0] elapsed_reg, elapsed_next;
    logic [63:0] total_reg, total_next;
    logic [31:0] frames_reg, frames_next;
    logic [31:0] fis_reg, fis_next;
    logic [31:0] rate_reg, rate_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    ucode_t      uw;
    logic        hold_true;
    logic        jump_true;
    logic        in_take;
    logic        out_full;
    logic [31:0] freq_eff;
    logic [63:0] freq64;
    logic [63:0] target64;
    logic [63:0] max64;
    logic [63:0] product;
    logic [63:0] snap_diff;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_busy;
    logic [63:0] div_quotient;
    logic [31:0] div_remainder;

    assign uw = ucode_rom(step_reg);

    // A zero counter frequency counts as one, both for the conversion and
    // for the one-second test.
    assign freq_eff = (counter_frequency_reg == '0) ? 32'd1 : counter_frequency_reg;
    assign freq64   = {32'd0, freq_eff};
    assign target64 = {32'd0, target_step_ticks_reg};
    assign max64    = {32'd0, max_delta_counts_reg};

    // The clamped delta fits in 32 bits, so one 32x32 product covers it.
    assign product  = {32'd0, work_reg[31:0]} * {32'd0, TPS_W};

    assign snap_diff = (work_reg >= target64) ? (work_reg - target64)
                                              : (target64 - work_reg);

    assign req.ready = (step_reg == STEP_ACCEPT);
    assign in_take   = req.valid && req.ready;
    assign out_full  = out_valid_reg && !rsp.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // The divider serves the tick conversion, the leftover modulo and the
    // one-second modulo, one at a time.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = work_reg;
        div_divisor  = freq_eff;
        unique case (uw.uop)
            U_CONV_START:
            begin
                div_start = 1'b1;
            end
            U_MOD_START:
            begin
                div_start    = 1'b1;
                div_dividend = leftover_reg;
                div_divisor  = target_step_ticks_reg;
            end
            U_SEC_START:
            begin
                div_start    = 1'b1;
                div_dividend = sec_acc_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    fsft_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Branch conditions of the current control word.
    always_comb
    begin
        unique case (uw.hold)
            C_NEVER:       hold_true = 1'b0;
            C_ALWAYS:      hold_true = 1'b1;
            C_NO_INPUT:    hold_true = !req.valid;
            C_REQ_RESET:   hold_true = req.data.op == OP_RESET;
            C_NOT_FIXED:   hold_true = !fixed_step_reg;
            C_NO_FIRE:     hold_true = leftover_reg < target64;
            C_TARGET_ZERO: hold_true = target_step_ticks_reg == '0;
            C_SEC_LOW:     hold_true = sec_acc_reg < freq64;
            C_DIV_BUSY:    hold_true = div_busy;
            C_OUT_FULL:    hold_true = out_full;
            default:       hold_true = 1'b0;
        endcase
        unique case (uw.jump)
            C_NEVER:       jump_true = 1'b0;
            C_ALWAYS:      jump_true = 1'b1;
            C_NO_INPUT:    jump_true = !req.valid;
            C_REQ_RESET:   jump_true = req.data.op == OP_RESET;
            C_NOT_FIXED:   jump_true = !fixed_step_reg;
            C_NO_FIRE:     jump_true = leftover_reg < target64;
            C_TARGET_ZERO: jump_true = target_step_ticks_reg == '0;
            C_SEC_LOW:     jump_true = sec_acc_reg < freq64;
            C_DIV_BUSY:    jump_true = div_busy;
            C_OUT_FULL:    jump_true = out_full;
            default:       jump_true = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (hold_true)
        begin
            step_next = step_reg;
        end
        else if (jump_true)
        begin
            step_next = uw.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // Configuration writes.
    always_comb
    begin
        counter_frequency_next = counter_frequency_reg;
        max_delta_counts_next  = max_delta_counts_reg;
        fixed_step_next        = fixed_step_reg;
        target_step_ticks_next = target_step_ticks_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COUNTER_FREQUENCY: counter_frequency_next = cfg_data;
                CFG_MAX_DELTA_COUNTS:  max_delta_counts_next  = cfg_data;
                CFG_FIXED_STEP:        fixed_step_next        = cfg_data[0];
                CFG_TARGET_STEP_TICKS: target_step_ticks_next = cfg_data;
                default:               fixed_step_next        = fixed_step_reg;
            endcase
        end
    end

    // Datapath driven by the control word.
    always_comb
    begin
        ts_next       = ts_reg;
        work_next     = work_reg;
        fired_next    = fired_reg;
        last_ts_next  = last_ts_reg;
        sec_acc_next  = sec_acc_reg;
        leftover_next = leftover_reg;
        elapsed_next  = elapsed_reg;
        total_next    = total_reg;
        frames_next   = frames_reg;
        fis_next      = fis_reg;
        rate_next     = rate_reg;
        out_data_next = out_data_reg;

        out_valid_next = out_valid_reg && !rsp.ready;

        unique case (uw.uop)
            U_ACCEPT:
            begin
                if (in_take)
                begin
                    ts_next    = req.data.timestamp;
                    fired_next = 1'b0;
                end
            end
            U_DELTA:
            begin
                // A timestamp that went backwards gives the wrapped difference.
                work_next    = ts_reg - last_ts_reg;
                last_ts_next = ts_reg;
            end
            U_ACCUM:
            begin
                sec_acc_next = sec_acc_reg + work_reg;
                if (work_reg > max64)
                begin
                    work_next = max64;
                end
            end
            U_MUL:
            begin
                work_next = product;
            end
            U_CONV_DONE:
            begin
                work_next = div_quotient;
            end
            U_SNAP:
            begin
                if (snap_diff < SNAP_WINDOW)
                begin
                    work_next = target64;
                end
            end
            U_LEFT_ADD:
            begin
                leftover_next = leftover_reg + work_reg;
            end
            U_FIRE_FIXED:
            begin
                elapsed_next = target64;
                total_next   = total_reg + target64;
                frames_next  = frames_reg + 1'b1;
                fis_next     = fis_reg + 1'b1;
                fired_next   = 1'b1;
                // A zero step leaves nothing over and skips the modulo.
                if (target_step_ticks_reg == '0)
                begin
                    leftover_next = '0;
                end
            end
            U_MOD_DONE:
            begin
                leftover_next = {32'd0, div_remainder};
            end
            U_FIRE_VAR:
            begin
                elapsed_next  = work_reg;
                total_next    = total_reg + work_reg;
                leftover_next = '0;
                frames_next   = frames_reg + 1'b1;
                fis_next      = fis_reg + 1'b1;
                fired_next    = 1'b1;
            end
            U_SEC_START:
            begin
                rate_next = fis_reg;
                fis_next  = '0;
            end
            U_SEC_DONE:
            begin
                sec_acc_next = {32'd0, div_remainder};
            end
            U_FINISH:
            begin
                if (!out_full)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{rendered:          fired_reg,
                                       elapsed_ticks:     elapsed_reg,
                                       total_ticks:       total_reg,
                                       frame_count:       frames_reg,
                                       frames_per_second: rate_reg};
                end
            end
            default:
            begin
                work_next = work_reg;
            end
        endcase

        // A reset op reloads the timestamp and clears leftover and rate state.
        if (uw.clear_elapsed)
        begin
            last_ts_next  = ts_reg;
            leftover_next = '0;
            rate_next     = '0;
            fis_next      = '0;
            sec_acc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_frequency_reg <= RST_COUNTER_FREQUENCY;
            max_delta_counts_reg  <= RST_MAX_DELTA_COUNTS;
            fixed_step_reg        <= RST_FIXED_STEP;
            target_step_ticks_reg <= RST_TARGET_STEP_TICKS;
            step_reg              <= STEP_ACCEPT;
            out_valid_reg         <= 1'b0;
            last_ts_reg           <= '0;
            sec_acc_reg           <= '0;
            leftover_reg          <= '0;
            elapsed_reg           <= '0;
            total_reg             <= '0;
            frames_reg            <= '0;
            fis_reg               <= '0;
            rate_reg              <= '0;
        end
        else
        begin
            counter_frequency_reg <= counter_frequency_next;
            max_delta_counts_reg  <= max_delta_counts_next;
            fixed_step_reg        <= fixed_step_next;
            target_step_ticks_reg <= target_step_ticks_next;
            step_reg              <= step_next;
            out_valid_reg         <= out_valid_next;
            last_ts_reg           <= last_ts_next;
            sec_acc_reg           <= sec_acc_next;
            leftover_reg          <= leftover_next;
            elapsed_reg           <= elapsed_next;
            total_reg             <= total_next;
            frames_reg            <= frames_next;
            fis_reg               <= fis_next;
            rate_reg              <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg       <= ts_next;
        work_reg     <= work_next;
        fired_reg    <= fired_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
